// ----- sv/deq_pkg.sv -----
// Shared types and codes for the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

	// Widths of the transaction fields
	localparam int unsigned KindBits  = 3;
	localparam int unsigned FieldBits = 32;
	localparam int unsigned CountBits = 11;

	// Operation codes; the two unused codes act as a query
	typedef enum logic [KindBits-1:0] {
		KIND_PUSH_FRONT = 3'd0,
		KIND_PUSH_BACK  = 3'd1,
		KIND_POP_FRONT  = 3'd2,
		KIND_POP_BACK   = 3'd3,
		KIND_CLEAR      = 3'd4,
		KIND_QUERY      = 3'd5
	} deq_kind_t;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} deq_status_t;

	// Input transaction
	typedef struct packed {
		logic [KindBits-1:0]         kind;
		logic signed [FieldBits-1:0] value;
	} deq_in_t;

	// Output transaction
	typedef struct packed {
		logic signed [FieldBits-1:0] popped;
		deq_status_t                 status;
		logic signed [FieldBits-1:0] front_word;
		logic signed [FieldBits-1:0] back_word;
		logic [CountBits-1:0]        count;
		logic                        is_empty;
	} deq_out_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic exec;
		logic load;
	} deq_cmd_t;

endpackage

// ----- sv/deq_ctrl.sv -----
// Controller state machine for the double-ended queue.
`timescale 1ns / 1ps

module deq_ctrl import deq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output deq_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_LOAD = 2'b10
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	// Decode handshakes into datapath commands
	assign in_ready = (state_q == S_IDLE);
	assign cmd.exec = in_valid && in_ready;
	assign cmd.load = (state_q == S_LOAD) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	// Advance the state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.exec) state_nxt = S_LOAD;
			end
			S_LOAD: begin
				if (cmd.load) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			// Hold the result until taken; a new one replaces it
			if (cmd.load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- sv/deq_datapath.sv -----
// Datapath for the double-ended queue: ring store, pointers and result register.
`timescale 1ns / 1ps

module deq_datapath import deq_pkg::*; #(
	parameter int unsigned DEPTH     = 1024,
	parameter int unsigned WORD_BITS = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  deq_cmd_t cmd,
	input  deq_in_t  in_data,
	output deq_out_t out_data
);

	localparam int unsigned AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW       = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
	localparam logic [AW-1:0] HeadRst = AW'(DEPTH / 2 - 1);
	localparam logic [AW-1:0] TailRst = AW'(DEPTH / 2);
	localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

	function automatic logic [AW-1:0] inc_idx(input logic [AW-1:0] i);
		return (i == LastIdx) ? '0 : AW'(i + 1'b1);
	endfunction

	function automatic logic [AW-1:0] dec_idx(input logic [AW-1:0] i);
		return (i == '0) ? LastIdx : AW'(i - 1'b1);
	endfunction

	// Sign-extend a stored word and cut it to the field width
	function automatic logic signed [FieldBits-1:0] to_field(input logic [WORD_BITS-1:0] w);
		logic signed [63:0] ext;
		ext = 64'(signed'(w));
		return ext[FieldBits-1:0];
	endfunction

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rdata_q;

	logic [AW-1:0]        head_q, tail_q;
	logic [CW-1:0]        count_q;
	logic [WORD_BITS-1:0] front_q, back_q;
	logic                 fix_front_q, fix_back_q;
	logic [WORD_BITS-1:0] popped_q;
	logic                 pop_ok_q;
	deq_status_t          status_q;

	logic [AW-1:0]        head_nxt, tail_nxt;
	logic [CW-1:0]        count_nxt;
	logic [WORD_BITS-1:0] front_nxt, back_nxt, popped_nxt;
	logic                 fix_front_nxt, fix_back_nxt, pop_ok_nxt;
	deq_status_t          status_nxt;
	logic                 mem_we, mem_re;
	logic [AW-1:0]        mem_waddr, mem_raddr;
	logic [WORD_BITS-1:0] push_word;
	logic                 is_full, is_empty_now;
	logic [WORD_BITS-1:0] front_cur, back_cur;

	assign push_word    = WORD_BITS'(64'($unsigned(in_data.value)));
	assign is_full      = (count_q == FullCnt);
	assign is_empty_now = (count_q == '0);

	// Decode the operation into pointer, cache and store updates
	always_comb begin
		head_nxt      = head_q;
		tail_nxt      = tail_q;
		count_nxt     = count_q;
		front_nxt     = front_q;
		back_nxt      = back_q;
		popped_nxt    = '0;
		pop_ok_nxt    = 1'b0;
		fix_front_nxt = 1'b0;
		fix_back_nxt  = 1'b0;
		status_nxt    = STAT_OK;
		mem_we        = 1'b0;
		mem_re        = 1'b0;
		mem_waddr     = head_q;
		mem_raddr     = head_q;
		unique case (in_data.kind)
			KIND_PUSH_FRONT: begin
				if (is_full) begin
					status_nxt = STAT_FULL;
				end else begin
					mem_we    = cmd.exec;
					mem_waddr = head_q;
					head_nxt  = dec_idx(head_q);
					count_nxt = CW'(count_q + 1'b1);
					front_nxt = push_word;
					if (is_empty_now) back_nxt = push_word;
				end
			end
			KIND_PUSH_BACK: begin
				if (is_full) begin
					status_nxt = STAT_FULL;
				end else begin
					mem_we    = cmd.exec;
					mem_waddr = tail_q;
					tail_nxt  = inc_idx(tail_q);
					count_nxt = CW'(count_q + 1'b1);
					back_nxt  = push_word;
					if (is_empty_now) front_nxt = push_word;
				end
			end
			KIND_POP_FRONT: begin
				if (is_empty_now) begin
					status_nxt = STAT_EMPTY;
				end else begin
					head_nxt      = inc_idx(head_q);
					count_nxt     = CW'(count_q - 1'b1);
					popped_nxt    = front_q;
					pop_ok_nxt    = 1'b1;
					// Fetch the word that becomes the new front
					mem_re        = cmd.exec;
					mem_raddr     = inc_idx(inc_idx(head_q));
					fix_front_nxt = 1'b1;
				end
			end
			KIND_POP_BACK: begin
				if (is_empty_now) begin
					status_nxt = STAT_EMPTY;
				end else begin
					tail_nxt     = dec_idx(tail_q);
					count_nxt    = CW'(count_q - 1'b1);
					popped_nxt   = back_q;
					pop_ok_nxt   = 1'b1;
					// Fetch the word that becomes the new back
					mem_re       = cmd.exec;
					mem_raddr    = dec_idx(dec_idx(tail_q));
					fix_back_nxt = 1'b1;
				end
			end
			KIND_CLEAR: begin
				head_nxt  = HeadRst;
				tail_nxt  = TailRst;
				count_nxt = '0;
			end
			default: begin
			end
		endcase
	end

	// Ring store with registered read
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= push_word;
		if (mem_re) rdata_q <= mem[mem_raddr];
	end

	// Pointers, count and control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= HeadRst;
			tail_q      <= TailRst;
			count_q     <= '0;
			fix_front_q <= 1'b0;
			fix_back_q  <= 1'b0;
			pop_ok_q    <= 1'b0;
			status_q    <= STAT_OK;
		end else if (cmd.exec) begin
			head_q      <= head_nxt;
			tail_q      <= tail_nxt;
			count_q     <= count_nxt;
			fix_front_q <= fix_front_nxt;
			fix_back_q  <= fix_back_nxt;
			pop_ok_q    <= pop_ok_nxt;
			status_q    <= status_nxt;
		end else if (cmd.load) begin
			fix_front_q <= 1'b0;
			fix_back_q  <= 1'b0;
		end
	end

	// Merge the fetched word into the front and back cache
	assign front_cur = fix_front_q ? rdata_q : front_q;
	assign back_cur  = fix_back_q ? rdata_q : back_q;

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			front_q  <= front_nxt;
			back_q   <= back_nxt;
			popped_q <= popped_nxt;
		end else if (cmd.load) begin
			front_q <= front_cur;
			back_q  <= back_cur;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_data.popped     <= pop_ok_q ? to_field(popped_q) : '0;
			out_data.status     <= status_q;
			out_data.front_word <= (count_q == '0) ? '0 : to_field(front_cur);
			out_data.back_word  <= (count_q == '0) ? '0 : to_field(back_cur);
			out_data.count      <= CountBits'(count_q);
			out_data.is_empty   <= (count_q == '0);
		end
	end

endmodule

// ----- sv/double_ended_queue.sv -----
// Top level of the double-ended queue: controller, datapath and checks.
`timescale 1ns / 1ps
//
// Double-ended queue of signed words in a ring store of DEPTH entries.
// Input channel (in_valid/in_ready/in_data) carries one operation per
// transaction: push front, push back, pop front, pop back, clear or query.
// Output channel (out_valid/out_ready/out_data) returns one result per
// transaction: popped word, status, front and back words, count, empty flag.
// Sequence: the cycle that accepts the input updates the pointers and issues
// the store read; the load state then takes the registered read data of the
// ring store into the result register, and out_valid rises with that load.
// A new transaction is accepted only once the result of the last one has
// been loaded into the result register.
// A result waiting on the output does not block acceptance of the next
// transaction; if the receiver stalls, that next result waits inside until
// the output register is taken, and no further input is accepted meanwhile.
// Reset (arst_n low) empties the queue: head at DEPTH/2-1, tail at DEPTH/2,
// count zero, no result pending. The store itself is not cleared.
//

module double_ended_queue import deq_pkg::*; #(
	parameter int unsigned DEPTH     = 1024,
	parameter int unsigned WORD_BITS = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  deq_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output deq_out_t out_data
);

	deq_cmd_t cmd;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	deq_datapath #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.out_data (out_data)
	);

	// One transaction in flight: no acceptance in the cycle after one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted on consecutive cycles");

	// Empty flag agrees with the count
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.is_empty == (out_data.count == '0)))
		else $error("empty flag disagrees with count");

	// Empty queue reports zero words
	a_empty_words: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_empty |->
			(out_data.front_word == '0) && (out_data.back_word == '0))
		else $error("non-zero front or back on empty queue");

	// Only a successful pop returns a word
	a_popped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status != STAT_OK) |-> (out_data.popped == '0))
		else $error("popped word on a failed operation");

endmodule

// ----- tb/sv/tb_double_ended_queue.sv -----
// Self-checking testbench for the double-ended queue: directed table, fill and random traffic.
`timescale 1ns / 1ps

module tb_double_ended_queue;
	import deq_pkg::*;

	localparam int unsigned DEPTH      = 1024;
	localparam int unsigned PTR_BITS   = $clog2(DEPTH);
	localparam int unsigned QUIET_MAX  = 2000;
	localparam int unsigned LONG_HOLD  = 40;

	// Kind codes with no operation of their own; the block treats them as a query
	localparam logic [KindBits-1:0] KIND_SPARE_A = 3'd6;
	localparam logic [KindBits-1:0] KIND_SPARE_B = 3'd7;

	localparam logic signed [FieldBits-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [FieldBits-1:0] WORD_MAX = 32'sh7FFF_FFFF;

	// One row of the directed table; result is used only where known is set
	typedef struct packed {
		deq_in_t  op;
		logic     known;
		deq_out_t result;
	} step_row_t;

	localparam int unsigned STEP_ROWS = 24;
	localparam step_row_t STEP_TABLE [STEP_ROWS] = '{
		'{'{KIND_QUERY,      32'sd0},        1'b1, '{32'sd0, STAT_OK, 32'sd0, 32'sd0, 11'd0, 1'b1}},
		'{'{KIND_POP_FRONT,  32'sd0},        1'b1, '{32'sd0, STAT_EMPTY, 32'sd0, 32'sd0, 11'd0, 1'b1}},
		'{'{KIND_POP_BACK,   32'sd0},        1'b1, '{32'sd0, STAT_EMPTY, 32'sd0, 32'sd0, 11'd0, 1'b1}},
		'{'{KIND_PUSH_FRONT, WORD_MIN},      1'b1, '{32'sd0, STAT_OK, WORD_MIN, WORD_MIN, 11'd1, 1'b0}},
		'{'{KIND_PUSH_BACK,  WORD_MAX},      1'b1, '{32'sd0, STAT_OK, WORD_MIN, WORD_MAX, 11'd2, 1'b0}},
		'{'{KIND_SPARE_A,    32'sh1234_5678}, 1'b1, '{32'sd0, STAT_OK, WORD_MIN, WORD_MAX, 11'd2, 1'b0}},
		'{'{KIND_SPARE_B,    32'shEDCB_A987}, 1'b1, '{32'sd0, STAT_OK, WORD_MIN, WORD_MAX, 11'd2, 1'b0}},
		'{'{KIND_POP_FRONT,  32'sd0},        1'b1, '{WORD_MIN, STAT_OK, WORD_MAX, WORD_MAX, 11'd1, 1'b0}},
		'{'{KIND_POP_BACK,   32'sd0},        1'b1, '{WORD_MAX, STAT_OK, 32'sd0, 32'sd0, 11'd0, 1'b1}},
		'{'{KIND_PUSH_BACK,  -32'sd1},       1'b0, '0},
		'{'{KIND_PUSH_FRONT, 32'sd0},        1'b0, '0},
		'{'{KIND_PUSH_BACK,  32'sh5555_5555}, 1'b0, '0},
		'{'{KIND_PUSH_FRONT, 32'shAAAA_AAAA}, 1'b0, '0},
		'{'{KIND_QUERY,      32'sd0},        1'b0, '0},
		'{'{KIND_POP_BACK,   32'sd0},        1'b0, '0},
		'{'{KIND_POP_FRONT,  32'sd0},        1'b0, '0},
		'{'{KIND_CLEAR,      32'sd0},        1'b1, '{32'sd0, STAT_OK, 32'sd0, 32'sd0, 11'd0, 1'b1}},
		'{'{KIND_POP_BACK,   32'sd0},        1'b1, '{32'sd0, STAT_EMPTY, 32'sd0, 32'sd0, 11'd0, 1'b1}},
		'{'{KIND_PUSH_BACK,  32'sd1},        1'b0, '0},
		'{'{KIND_PUSH_BACK,  32'sd2},        1'b0, '0},
		'{'{KIND_POP_FRONT,  32'sd0},        1'b0, '0},
		'{'{KIND_POP_FRONT,  32'sd0},        1'b0, '0},
		'{'{KIND_POP_FRONT,  32'sd0},        1'b1, '{32'sd0, STAT_EMPTY, 32'sd0, 32'sd0, 11'd0, 1'b1}},
		'{'{KIND_QUERY,      32'sd0},        1'b1, '{32'sd0, STAT_OK, 32'sd0, 32'sd0, 11'd0, 1'b1}}
	};

	logic     clk = 1'b0;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	deq_in_t  in_data;
	logic     out_valid;
	logic     out_ready;
	deq_out_t out_data;

	// Shadow of the queue contents and pointers
	logic signed [FieldBits-1:0] ring_mem [DEPTH];
	logic [PTR_BITS-1:0]         head_ptr;
	logic [PTR_BITS-1:0]         tail_ptr;
	int unsigned                 held;

	deq_out_t    expected_q [$];
	int unsigned fail_count   = 0;
	int unsigned quiet_cycles = 0;
	int unsigned hold_off_req = 0;
	bit          idle_on      = 1'b1;
	bit          stall_on     = 1'b1;

	double_ended_queue #(
		.DEPTH(DEPTH),
		.WORD_BITS(FieldBits)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one operation to the shadow queue and return the result it should produce
	function automatic deq_out_t predict_op(deq_in_t op);
		deq_out_t            res;
		logic [PTR_BITS-1:0] first_idx;
		logic [PTR_BITS-1:0] last_idx;
		res = '0;
		res.status = STAT_OK;
		case (op.kind)
			KIND_PUSH_FRONT: begin
				if (held == DEPTH) begin
					res.status = STAT_FULL;
				end else begin
					ring_mem[head_ptr] = op.value;
					head_ptr = head_ptr - 1'b1;
					held++;
				end
			end
			KIND_PUSH_BACK: begin
				if (held == DEPTH) begin
					res.status = STAT_FULL;
				end else begin
					ring_mem[tail_ptr] = op.value;
					tail_ptr = tail_ptr + 1'b1;
					held++;
				end
			end
			KIND_POP_FRONT: begin
				if (held == 0) begin
					res.status = STAT_EMPTY;
				end else begin
					head_ptr = head_ptr + 1'b1;
					res.popped = ring_mem[head_ptr];
					held--;
				end
			end
			KIND_POP_BACK: begin
				if (held == 0) begin
					res.status = STAT_EMPTY;
				end else begin
					tail_ptr = tail_ptr - 1'b1;
					res.popped = ring_mem[tail_ptr];
					held--;
				end
			end
			KIND_CLEAR: begin
				head_ptr = PTR_BITS'(DEPTH / 2 - 1);
				tail_ptr = PTR_BITS'(DEPTH / 2);
				held = 0;
			end
			default: begin
			end
		endcase
		if (held != 0) begin
			first_idx = head_ptr + 1'b1;
			last_idx = tail_ptr - 1'b1;
			res.front_word = ring_mem[first_idx];
			res.back_word = ring_mem[last_idx];
		end
		res.count = CountBits'(held);
		res.is_empty = (held == 0);
		return res;
	endfunction

	// Random word, with the extremes and the all-zero and all-one patterns mixed in
	function automatic logic signed [FieldBits-1:0] rand_word();
		case ($urandom_range(0, 15))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2: return '0;
			3: return '1;
			default: return $urandom();
		endcase
	endfunction

	// Random operation; the share left after pushes and pops goes to clear, query and spare codes
	function automatic deq_in_t make_op(int unsigned push_pct, int unsigned pop_pct,
			int unsigned front_pct);
		deq_in_t     op;
		int unsigned pick;
		bit          at_front;
		pick = $urandom_range(0, 99);
		at_front = ($urandom_range(0, 99) < front_pct);
		op.value = rand_word();
		if (pick < push_pct) begin
			op.kind = at_front ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
		end else if (pick < push_pct + pop_pct) begin
			op.kind = at_front ? KIND_POP_FRONT : KIND_POP_BACK;
		end else begin
			case ($urandom_range(0, 9))
				0: op.kind = KIND_CLEAR;
				1: op.kind = KIND_SPARE_A;
				2: op.kind = KIND_SPARE_B;
				default: op.kind = KIND_QUERY;
			endcase
		end
		return op;
	endfunction

	// Offer one transaction, wait for acceptance, then log its expected result
	task automatic send_op(deq_in_t op, logic known, deq_out_t known_res);
		deq_out_t predicted;
		in_data <= op;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		predicted = predict_op(op);
		expected_q.insert(expected_q.size(), known ? known_res : predicted);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic check_field(string name, logic [FieldBits-1:0] want,
			logic [FieldBits-1:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
		end
	endtask

	// Receiver: random stalls, plus one long hold-off counted here on request
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req != 0) begin
				out_ready <= 1'b0;
				for (int unsigned n = 0; n < hold_off_req; n++) @(posedge clk);
				hold_off_req = 0;
				out_ready <= 1'b1;
			end else if (stall_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		deq_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				fail_count++;
				$display("%0t: result with nothing expected, got %h", $time, out_data);
			end else begin
				want = expected_q[0];
				expected_q.delete(0);
				check_field("popped", want.popped, out_data.popped);
				check_field("status", FieldBits'(want.status), FieldBits'(out_data.status));
				check_field("front_word", want.front_word, out_data.front_word);
				check_field("back_word", want.back_word, out_data.back_word);
				check_field("count", FieldBits'(want.count), FieldBits'(out_data.count));
				check_field("is_empty", FieldBits'(want.is_empty),
					FieldBits'(out_data.is_empty));
			end
		end
	end

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_MAX) begin
			$display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
			$display("double_ended_queue test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		deq_in_t op;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		head_ptr = PTR_BITS'(DEPTH / 2 - 1);
		tail_ptr = PTR_BITS'(DEPTH / 2);
		held = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		for (int unsigned r = 0; r < STEP_ROWS; r++)
			send_op(STEP_TABLE[r].op, STEP_TABLE[r].known, STEP_TABLE[r].result);

		// Pause the sender until every result is back
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);

		// Balanced random traffic, with one long receiver hold-off to back up the input
		for (int unsigned i = 0; i < 120; i++) begin
			if (i == 40)
				hold_off_req = LONG_HOLD;
			send_op(make_op(44, 44, 50), 1'b0, '0);
		end

		// Fill to full from alternate ends, so that both pointers wrap
		op.kind = KIND_CLEAR;
		op.value = rand_word();
		send_op(op, 1'b0, '0);
		while (held < DEPTH) begin
			op.kind = held[0] ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
			op.value = rand_word();
			send_op(op, 1'b0, '0);
		end

		// Drop pushes on a full ring
		repeat (8) send_op(make_op(100, 0, 50), 1'b0, '0);

		// Rotate a full ring with no gaps on the input
		idle_on = 1'b0;
		repeat (30) begin
			op.kind = KIND_POP_FRONT;
			op.value = rand_word();
			send_op(op, 1'b0, '0);
			op.kind = KIND_PUSH_BACK;
			op.value = rand_word();
			send_op(op, 1'b0, '0);
		end
		idle_on = 1'b1;
		repeat (4) send_op(make_op(100, 0, 50), 1'b0, '0);

		// Drain a stretch from both ends, then clear
		repeat (40) send_op(make_op(10, 85, 50), 1'b0, '0);
		op.kind = KIND_CLEAR;
		op.value = rand_word();
		send_op(op, 1'b0, '0);

		// Last stretch at full rate on both sides
		idle_on = 1'b0;
		stall_on = 1'b0;
		repeat (100) send_op(make_op(45, 45, 50), 1'b0, '0);

		// Wait for the tail of the results, then let the clock run on to catch strays
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		if (fail_count == 0 && expected_q.size() == 0) begin
			$display("double_ended_queue test passed");
		end else begin
			$display("double_ended_queue test failed");
		end
		$finish;
	end

endmodule

// ----- double_ended_queue.f -----
sv/deq_pkg.sv
sv/deq_ctrl.sv
sv/deq_datapath.sv
sv/double_ended_queue.sv
tb/sv/tb_double_ended_queue.sv
